/* hdl/vat_pkg.sv */
// shared constants and types of the vertex affine transform
`default_nettype none

package vat_pkg;

	// trig values: signed Q1.16
	localparam int TRIG_WIDTH = 18;
	localparam int TRIG_FRAC  = 16;

	// rotation angle register: signed Q2.16 radians
	localparam int ANGLE_WIDTH   = 19;
	localparam int ANGLE_PI      = 205887;
	localparam int ANGLE_HALF_PI = 102944;

	// cordic setup
	localparam int CORDIC_STEPS = 16;
	localparam int CORDIC_GUARD = 8;
	localparam int CORDIC_START = 10188014;
	localparam int TRIG_MAX     = 131071;
	localparam int TRIG_MIN     = -131072;
	localparam int ATAN_WIDTH   = 17;

	localparam logic [ATAN_WIDTH-1:0] ATAN_TAB [CORDIC_STEPS] = '{
		17'd51472, 17'd30386, 17'd16055, 17'd8150, 17'd4091, 17'd2047, 17'd1024, 17'd512,
		17'd256,   17'd128,   17'd64,    17'd32,   17'd16,   17'd8,    17'd4,    17'd2
	};

	// operation codes of the mode register
	localparam int MODE_WIDTH = 3;
	localparam logic [MODE_WIDTH-1:0] MODE_TRANSLATE = 3'd0;
	localparam logic [MODE_WIDTH-1:0] MODE_ROT_X     = 3'd1;
	localparam logic [MODE_WIDTH-1:0] MODE_ROT_Y     = 3'd2;
	localparam logic [MODE_WIDTH-1:0] MODE_ROT_Z     = 3'd3;
	localparam logic [MODE_WIDTH-1:0] MODE_SCALE     = 3'd4;

	// register indexes of the write port
	localparam int REG_INDEX_WIDTH = 3;
	localparam logic [REG_INDEX_WIDTH-1:0] REG_MODE    = 3'd0;
	localparam logic [REG_INDEX_WIDTH-1:0] REG_ANGLE   = 3'd1;
	localparam logic [REG_INDEX_WIDTH-1:0] REG_SHIFT_X = 3'd2;
	localparam logic [REG_INDEX_WIDTH-1:0] REG_SHIFT_Y = 3'd3;
	localparam logic [REG_INDEX_WIDTH-1:0] REG_SHIFT_Z = 3'd4;
	localparam logic [REG_INDEX_WIDTH-1:0] REG_SCALE   = 3'd5;

	// per-stage load enables of the datapath pipeline
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} vat_adv_t;

endpackage

`default_nettype wire

/* hdl/vertex_affine_transform.sv */
// Vertex affine transform: five-stage pipeline, one vertex accepted per cycle while
// in_stall is low; throughput is one vertex per cycle while out_stall is low, set
// by the fully pipelined split multipliers of each lane.
// A write to the angle register runs a 16-step cordic and holds in_stall high
// while it runs. Reset (arst_n low) empties the pipeline and restores every
// configuration register: translate mode, zero angle and shifts, scale 1.0.
`default_nettype none

module vertex_affine_transform #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	// configuration writes
	input  wire logic                                      wr_en,
	input  wire logic [vat_pkg::REG_INDEX_WIDTH-1:0]       wr_index,
	input  wire logic [((COORD_WIDTH > vat_pkg::ANGLE_WIDTH) ?
	                    COORD_WIDTH : vat_pkg::ANGLE_WIDTH)-1:0] wr_data,
	// vertex requests
	input  wire logic                                      in_valid,
	output logic                                           in_stall,
	input  wire logic [COORD_WIDTH-1:0]                    x_in,
	input  wire logic [COORD_WIDTH-1:0]                    y_in,
	input  wire logic [COORD_WIDTH-1:0]                    z_in,
	input  wire logic                                      is_last,
	// transformed vertices
	output logic                                           out_valid,
	input  wire logic                                      out_stall,
	output logic [COORD_WIDTH-1:0]                         x_out,
	output logic [COORD_WIDTH-1:0]                         y_out,
	output logic [COORD_WIDTH-1:0]                         z_out,
	output logic                                           is_last_out
);
	import vat_pkg::*;

	localparam int COEF_WIDTH = (COORD_WIDTH > TRIG_WIDTH) ? COORD_WIDTH : TRIG_WIDTH + 1;
	localparam logic [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	// configuration registers
	logic [MODE_WIDTH-1:0]   mode_q;
	logic [COORD_WIDTH-1:0]  shift_x_q;
	logic [COORD_WIDTH-1:0]  shift_y_q;
	logic [COORD_WIDTH-1:0]  shift_z_q;
	logic [COORD_WIDTH-1:0]  scale_q;

	// trig values
	logic signed [TRIG_WIDTH-1:0] cos_value;
	logic signed [TRIG_WIDTH-1:0] sin_value;
	logic                         cordic_busy;
	logic [COEF_WIDTH-1:0]        c_op;
	logic [COEF_WIDTH-1:0]        s_op;
	logic [COEF_WIDTH-1:0]        ns_op;
	logic [COEF_WIDTH-1:0]        k_op;

	// pipeline control
	logic     vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic     last_s1, last_s2, last_s3, last_s4, last_s5;
	vat_adv_t adv;

	// lane operands
	logic [COORD_WIDTH-1:0] xa1, xa2, ya1, ya2, za1, za2;
	logic [COEF_WIDTH-1:0]  xb1, xb2, yb1, yb2, zb1, zb2;
	logic [COORD_WIDTH-1:0] x_byp, y_byp, z_byp;
	logic                   mul, frac;

	function automatic logic [COORD_WIDTH-1:0] sat_add(input logic [COORD_WIDTH-1:0] a,
	                                                   input logic [COORD_WIDTH-1:0] b);
		logic [COORD_WIDTH:0] s;
		s = {a[COORD_WIDTH-1], a} + {b[COORD_WIDTH-1], b};
		if (s[COORD_WIDTH] != s[COORD_WIDTH-1])
			sat_add = s[COORD_WIDTH] ? C_MIN : C_MAX;
		else
			sat_add = s[COORD_WIDTH-1:0];
	endfunction

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_TRANSLATE;
			shift_x_q <= '0;
			shift_y_q <= '0;
			shift_z_q <= '0;
			scale_q   <= COORD_WIDTH'(1) << FRAC_BITS;
		end else if (wr_en) begin
			case (wr_index)
				REG_MODE:    mode_q    <= wr_data[MODE_WIDTH-1:0];
				REG_SHIFT_X: shift_x_q <= wr_data[COORD_WIDTH-1:0];
				REG_SHIFT_Y: shift_y_q <= wr_data[COORD_WIDTH-1:0];
				REG_SHIFT_Z: shift_z_q <= wr_data[COORD_WIDTH-1:0];
				REG_SCALE:   scale_q   <= wr_data[COORD_WIDTH-1:0];
				default: begin
				end
			endcase
		end
	end

	vat_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_angle  (wr_en && (wr_index == REG_ANGLE)),
		.angle     (wr_data[ANGLE_WIDTH-1:0]),
		.cos_value (cos_value),
		.sin_value (sin_value),
		.busy      (cordic_busy)
	);

	// coefficients at multiplier width
	always_comb begin
		c_op  = COEF_WIDTH'(cos_value);
		s_op  = COEF_WIDTH'(sin_value);
		ns_op = -s_op;
		k_op  = COEF_WIDTH'($signed(scale_q));
	end

	// operand selection per mode
	always_comb begin
		xa1 = x_in; xb1 = '0; xa2 = '0; xb2 = '0;
		ya1 = y_in; yb1 = '0; ya2 = '0; yb2 = '0;
		za1 = z_in; zb1 = '0; za2 = '0; zb2 = '0;
		x_byp = x_in;
		y_byp = y_in;
		z_byp = z_in;
		mul   = 1'b0;
		frac  = 1'b0;
		case (mode_q)
			MODE_TRANSLATE: begin
				x_byp = sat_add(x_in, shift_x_q);
				y_byp = sat_add(y_in, shift_y_q);
				z_byp = sat_add(z_in, shift_z_q);
			end
			MODE_ROT_X: begin
				mul = 1'b1;
				xa1 = '0;   xb1 = '0;    xa2 = '0;   xb2 = '0;
				x_byp = x_in;
				ya1 = y_in; yb1 = c_op;  ya2 = z_in; yb2 = s_op;
				za1 = y_in; zb1 = ns_op; za2 = z_in; zb2 = c_op;
			end
			MODE_ROT_Y: begin
				mul = 1'b1;
				xa1 = x_in; xb1 = c_op;  xa2 = z_in; xb2 = ns_op;
				za1 = x_in; zb1 = s_op;  za2 = z_in; zb2 = c_op;
			end
			MODE_ROT_Z: begin
				mul = 1'b1;
				xa1 = x_in; xb1 = c_op;  xa2 = y_in; xb2 = s_op;
				ya1 = x_in; yb1 = ns_op; ya2 = y_in; yb2 = c_op;
			end
			MODE_SCALE: begin
				mul  = 1'b1;
				frac = 1'b1;
				xb1  = k_op;
				yb1  = k_op;
				zb1  = k_op;
			end
			default: begin
			end
		endcase
	end

	// per-lane result select: lanes untouched by a rotation pass through
	logic x_mul, y_mul, z_mul;
	assign x_mul = mul && (mode_q != MODE_ROT_X);
	assign y_mul = mul && (mode_q != MODE_ROT_Y);
	assign z_mul = mul && (mode_q != MODE_ROT_Z);

	// stage load enables, a stage moves when empty or when its successor moves
	always_comb begin
		adv.s5 = !vld_s5 || !out_stall;
		adv.s4 = !vld_s4 || adv.s5;
		adv.s3 = !vld_s3 || adv.s4;
		adv.s2 = !vld_s2 || adv.s3;
		adv.s1 = !vld_s1 || adv.s2;
	end

	assign in_stall = !adv.s1 || cordic_busy;

	// valid bits travel with the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (adv.s1) vld_s1 <= in_valid && !cordic_busy;
			if (adv.s2) vld_s2 <= vld_s1;
			if (adv.s3) vld_s3 <= vld_s2;
			if (adv.s4) vld_s4 <= vld_s3;
			if (adv.s5) vld_s5 <= vld_s4;
		end
	end

	// last-vertex mark
	always_ff @(posedge clk) begin
		if (adv.s1) last_s1 <= is_last;
		if (adv.s2) last_s2 <= last_s1;
		if (adv.s3) last_s3 <= last_s2;
		if (adv.s4) last_s4 <= last_s3;
		if (adv.s5) last_s5 <= last_s4;
	end

	vat_lane #(
		.COORD_WIDTH (COORD_WIDTH),
		.FRAC_BITS   (FRAC_BITS),
		.COEF_WIDTH  (COEF_WIDTH)
	) u_lane_x (
		.clk    (clk),
		.adv    (adv),
		.a1     (xa1),
		.b1     (xb1),
		.a2     (xa2),
		.b2     (xb2),
		.byp    (x_byp),
		.mul    (x_mul),
		.frac   (frac),
		.result (x_out)
	);

	vat_lane #(
		.COORD_WIDTH (COORD_WIDTH),
		.FRAC_BITS   (FRAC_BITS),
		.COEF_WIDTH  (COEF_WIDTH)
	) u_lane_y (
		.clk    (clk),
		.adv    (adv),
		.a1     (ya1),
		.b1     (yb1),
		.a2     (ya2),
		.b2     (yb2),
		.byp    (y_byp),
		.mul    (y_mul),
		.frac   (frac),
		.result (y_out)
	);

	vat_lane #(
		.COORD_WIDTH (COORD_WIDTH),
		.FRAC_BITS   (FRAC_BITS),
		.COEF_WIDTH  (COEF_WIDTH)
	) u_lane_z (
		.clk    (clk),
		.adv    (adv),
		.a1     (za1),
		.b1     (zb1),
		.a2     (za2),
		.b2     (zb2),
		.byp    (z_byp),
		.mul    (z_mul),
		.frac   (frac),
		.result (z_out)
	);

	assign out_valid   = vld_s5;
	assign is_last_out = last_s5;

endmodule

`default_nettype wire

/* hdl/vat_cordic.sv */
// iterative cordic that turns the angle register into cosine and sine
`default_nettype none

module vat_cordic (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 wr_angle,
	input  wire logic [vat_pkg::ANGLE_WIDTH-1:0]      angle,
	output logic signed [vat_pkg::TRIG_WIDTH-1:0]     cos_value,
	output logic signed [vat_pkg::TRIG_WIDTH-1:0]     sin_value,
	output logic                                      busy
);
	import vat_pkg::*;

	localparam int XW  = 27;
	localparam int ZW  = 20;
	localparam int RW  = 20;
	localparam int CNT = $clog2(CORDIC_STEPS);

	localparam logic [1:0] CS_IDLE = 2'd0;
	localparam logic [1:0] CS_RUN  = 2'd1;
	localparam logic [1:0] CS_DONE = 2'd2;

	localparam logic signed [ZW-1:0] PI_Z      = ZW'(ANGLE_PI);
	localparam logic signed [ZW-1:0] HALF_PI_Z = ZW'(ANGLE_HALF_PI);
	localparam logic signed [XW-1:0] X_START   = XW'(CORDIC_START);
	localparam logic signed [XW-1:0] X_ROUND   = XW'(1 << (CORDIC_GUARD - 1));
	localparam logic signed [RW-1:0] T_MAX     = RW'(TRIG_MAX);
	localparam logic signed [RW-1:0] T_MIN     = RW'(TRIG_MIN);

	logic [1:0]              state_q;
	logic [CNT-1:0]          step_q;
	logic                    flip_q;
	logic signed [XW-1:0]    x_q;
	logic signed [XW-1:0]    y_q;
	logic signed [ZW-1:0]    z_q;
	logic signed [TRIG_WIDTH-1:0] cos_q;
	logic signed [TRIG_WIDTH-1:0] sin_q;

	logic signed [ZW-1:0]    a_ext;
	logic signed [ZW-1:0]    a_clamp;
	logic signed [ZW-1:0]    z_start;
	logic                    flip_start;
	logic signed [XW-1:0]    dx;
	logic signed [XW-1:0]    dy;
	logic signed [ZW-1:0]    atan_z;
	logic signed [XW-1:0]    x_rnd;
	logic signed [XW-1:0]    y_rnd;
	logic signed [RW-1:0]    x_fin;
	logic signed [RW-1:0]    y_fin;

	function automatic logic signed [TRIG_WIDTH-1:0] clamp_trig(input logic signed [RW-1:0] v);
		if (v > T_MAX)
			clamp_trig = T_MAX[TRIG_WIDTH-1:0];
		else if (v < T_MIN)
			clamp_trig = T_MIN[TRIG_WIDTH-1:0];
		else
			clamp_trig = v[TRIG_WIDTH-1:0];
	endfunction

	// clamp to +-pi and fold into +-pi/2
	always_comb begin
		a_ext = {{(ZW-ANGLE_WIDTH){angle[ANGLE_WIDTH-1]}}, angle};
		if (a_ext > PI_Z)
			a_clamp = PI_Z;
		else if (a_ext < -PI_Z)
			a_clamp = -PI_Z;
		else
			a_clamp = a_ext;
		if (a_clamp > HALF_PI_Z) begin
			z_start    = a_clamp - PI_Z;
			flip_start = 1'b1;
		end else if (a_clamp < -HALF_PI_Z) begin
			z_start    = a_clamp + PI_Z;
			flip_start = 1'b1;
		end else begin
			z_start    = a_clamp;
			flip_start = 1'b0;
		end
	end

	// one micro-rotation
	assign dx     = y_q >>> step_q;
	assign dy     = x_q >>> step_q;
	assign atan_z = ZW'(ATAN_TAB[step_q]);

	// round off the guard bits and undo the fold
	always_comb begin
		x_rnd = (x_q + X_ROUND) >>> CORDIC_GUARD;
		y_rnd = (y_q + X_ROUND) >>> CORDIC_GUARD;
		x_fin = flip_q ? -x_rnd[RW-1:0] : x_rnd[RW-1:0];
		y_fin = flip_q ? -y_rnd[RW-1:0] : y_rnd[RW-1:0];
	end

	// sequencer and held results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			step_q  <= '0;
			cos_q   <= TRIG_WIDTH'(1 << TRIG_FRAC);
			sin_q   <= '0;
		end else if (wr_angle) begin
			state_q <= CS_RUN;
			step_q  <= '0;
		end else begin
			case (state_q)
				CS_RUN: begin
					step_q <= step_q + CNT'(1);
					if (step_q == CNT'(CORDIC_STEPS - 1))
						state_q <= CS_DONE;
				end
				CS_DONE: begin
					cos_q   <= clamp_trig(x_fin);
					sin_q   <= clamp_trig(y_fin);
					state_q <= CS_IDLE;
				end
				default: begin
					state_q <= CS_IDLE;
				end
			endcase
		end
	end

	// rotation vector
	always_ff @(posedge clk) begin
		if (wr_angle) begin
			x_q    <= X_START;
			y_q    <= '0;
			z_q    <= z_start;
			flip_q <= flip_start;
		end else if (state_q == CS_RUN) begin
			if (!z_q[ZW-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - atan_z;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + atan_z;
			end
		end
	end

	assign cos_value = cos_q;
	assign sin_value = sin_q;
	assign busy      = (state_q != CS_IDLE);

endmodule

`default_nettype wire

/* hdl/vat_lane.sv */
// one coordinate lane: two split multiplies, sum, rounding and saturation
`default_nettype none

module vat_lane #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16,
	parameter int COEF_WIDTH  = 32
) (
	input  wire logic                          clk,
	input  wire vat_pkg::vat_adv_t             adv,
	input  wire logic [COORD_WIDTH-1:0]        a1,
	input  wire logic [COEF_WIDTH-1:0]         b1,
	input  wire logic [COORD_WIDTH-1:0]        a2,
	input  wire logic [COEF_WIDTH-1:0]         b2,
	input  wire logic [COORD_WIDTH-1:0]        byp,
	input  wire logic                          mul,
	input  wire logic                          frac,
	output logic [COORD_WIDTH-1:0]             result
);
	import vat_pkg::*;

	localparam int AL = COORD_WIDTH / 2;
	localparam int AH = COORD_WIDTH - AL;
	localparam int BL = COEF_WIDTH / 2;
	localparam int BH = COEF_WIDTH - BL;
	localparam int PW = COORD_WIDTH + COEF_WIDTH;
	localparam int SW = PW + 1;

	localparam logic [SW-1:0] RND_FRAC = SW'(1) << (FRAC_BITS - 1);
	localparam logic [SW-1:0] RND_TRIG = SW'(1) << (TRIG_FRAC - 1);
	localparam logic [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	// stage 1: operands
	logic [COORD_WIDTH-1:0] a_s1 [2];
	logic [COEF_WIDTH-1:0]  b_s1 [2];
	logic [COORD_WIDTH-1:0] byp_s1;
	logic                   mul_s1;
	logic                   frac_s1;

	// stage 2: partial products
	logic        [AL+BL-1:0]   ll_s2 [2];
	logic signed [AH+BL:0]     hl_s2 [2];
	logic signed [AL+BH:0]     lh_s2 [2];
	logic signed [AH+BH-1:0]   hh_s2 [2];
	logic [COORD_WIDTH-1:0]    byp_s2;
	logic                      mul_s2;
	logic                      frac_s2;

	// stage 3: full products
	logic signed [PW-1:0]      p_s3 [2];
	logic [COORD_WIDTH-1:0]    byp_s3;
	logic                      mul_s3;
	logic                      frac_s3;

	// stage 4: rounded sum
	logic signed [SW-1:0]      sum_s4;
	logic [COORD_WIDTH-1:0]    byp_s4;
	logic                      mul_s4;
	logic                      frac_s4;

	// stage 5: result
	logic [COORD_WIDTH-1:0]    result_s5;

	logic signed [PW-1:0]      p_full [2];
	logic signed [SW-1:0]      shifted;
	logic [SW-COORD_WIDTH:0]   sat_hi;
	logic [COORD_WIDTH-1:0]    sat_val;

	// operand capture
	always_ff @(posedge clk) begin
		if (adv.s1) begin
			a_s1[0] <= a1;
			a_s1[1] <= a2;
			b_s1[0] <= b1;
			b_s1[1] <= b2;
			byp_s1  <= byp;
			mul_s1  <= mul;
			frac_s1 <= frac;
		end
	end

	// four half-width partial products per multiply
	always_ff @(posedge clk) begin
		if (adv.s2) begin
			for (int k = 0; k < 2; k++) begin
				ll_s2[k] <= (AL+BL)'(a_s1[k][AL-1:0]) * (AL+BL)'(b_s1[k][BL-1:0]);
				hl_s2[k] <= (AH+BL+1)'($signed(a_s1[k][COORD_WIDTH-1:AL]))
				          * (AH+BL+1)'($signed({1'b0, b_s1[k][BL-1:0]}));
				lh_s2[k] <= (AL+BH+1)'($signed({1'b0, a_s1[k][AL-1:0]}))
				          * (AL+BH+1)'($signed(b_s1[k][COEF_WIDTH-1:BL]));
				hh_s2[k] <= (AH+BH)'($signed(a_s1[k][COORD_WIDTH-1:AL]))
				          * (AH+BH)'($signed(b_s1[k][COEF_WIDTH-1:BL]));
			end
			byp_s2  <= byp_s1;
			mul_s2  <= mul_s1;
			frac_s2 <= frac_s1;
		end
	end

	// recombine partial products
	always_comb begin
		for (int k = 0; k < 2; k++) begin
			p_full[k] = (PW'(hh_s2[k]) <<< (AL + BL)) + (PW'(hl_s2[k]) <<< AL)
			          + (PW'(lh_s2[k]) <<< BL) + $signed(PW'(ll_s2[k]));
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			p_s3[0] <= p_full[0];
			p_s3[1] <= p_full[1];
			byp_s3  <= byp_s2;
			mul_s3  <= mul_s2;
			frac_s3 <= frac_s2;
		end
	end

	// sum of both products plus half an lsb
	always_ff @(posedge clk) begin
		if (adv.s4) begin
			sum_s4  <= $signed(SW'(p_s3[0]) + SW'(p_s3[1]) + (frac_s3 ? RND_FRAC : RND_TRIG));
			byp_s4  <= byp_s3;
			mul_s4  <= mul_s3;
			frac_s4 <= frac_s3;
		end
	end

	// scale back and saturate to the coordinate range
	always_comb begin
		shifted = frac_s4 ? (sum_s4 >>> FRAC_BITS) : (sum_s4 >>> TRIG_FRAC);
		sat_hi  = shifted[SW-1:COORD_WIDTH-1];
		if ((&sat_hi) || !(|sat_hi))
			sat_val = shifted[COORD_WIDTH-1:0];
		else
			sat_val = shifted[SW-1] ? C_MIN : C_MAX;
	end

	always_ff @(posedge clk) begin
		if (adv.s5)
			result_s5 <= mul_s4 ? sat_val : byp_s4;
	end

	assign result = result_s5;

endmodule

`default_nettype wire
